// ----- rtl/gbwa_pkg.sv -----
// shared types, constants and an arithmetic helper for the group-by aggregator
package gbwa_pkg;

  localparam int GBWA_MAX_GROUPS = 256;
  localparam int GBWA_VARS       = 4;
  localparam int GBWA_KEY_BITS   = 64;

  localparam logic        ACT_ACCUM = 1'b0;
  localparam logic        ACT_READ  = 1'b1;
  localparam logic [47:0] W48_MAX   = 48'hFFFF_FFFF_FFFF;
  localparam logic [63:0] S64_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] S64_MIN   = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic        action;
    logic [63:0] group_key;
    logic [31:0] obs_weight;
    logic signed [31:0] value_0;
    logic signed [31:0] value_1;
    logic signed [31:0] value_2;
    logic signed [31:0] value_3;
    logic [7:0]  read_index;
  } item_t;

  typedef struct packed {
    logic [7:0]  group_index;
    logic        created;
    logic        error_flag;
    logic [63:0] out_key;
    logic [47:0] total_weight;
    logic signed [63:0] result_0;
    logic signed [63:0] result_1;
    logic signed [63:0] result_2;
    logic signed [63:0] result_3;
    logic [8:0]  group_count;
  } result_t;

  // head of the command queue as seen by the back end
  typedef struct packed {
    logic  valid;
    item_t item;
  } qhead_t;

  typedef enum logic [2:0] {
    B_IDLE, B_SRCH, B_WRD, B_WUPD, B_SRD, B_SUPD, B_DIV, B_DONE
  } bstate_t;

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) return a[63] ? S64_MIN : S64_MAX;
    return s;
  endfunction

endpackage

// ----- rtl/gbwa_front.sv -----
// front end: command intake, key masking and a two-entry command queue
module gbwa_front #(
  parameter int KEY_BITS = gbwa_pkg::GBWA_KEY_BITS
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  gbwa_pkg::item_t item,
  output gbwa_pkg::qhead_t head,
  input  logic            pop
);
  gbwa_pkg::item_t ent [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       push;
  gbwa_pkg::item_t cls;

  always_comb begin
    cls = item;
    cls.group_key = 64'(item.group_key[KEY_BITS-1:0]);
  end

  assign busy = (count == 2'd2);
  assign push = start && !busy;
  assign head.valid = (count != 2'd0);
  assign head.item  = ent[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent[wr_ptr] <= cls;
  end
endmodule

// ----- rtl/gbwa_div.sv -----
// sequential signed divide (sum << 16) / weight, truncating, saturated to 64 bits
module gbwa_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [63:0] sum,
  input  logic [47:0] weight,
  output logic        done,
  output logic [63:0] quot
);
  localparam int NB = 80;

  logic [NB-1:0] num;
  logic [48:0]   rem;
  logic [47:0]   div;
  logic          neg;
  logic          run;
  logic [6:0]    cnt;
  logic [48:0]   rem_sh;
  logic          ge;

  assign rem_sh = {rem[47:0], num[NB-1]};
  assign ge     = (rem_sh >= {1'b0, div});

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        cnt <= 7'd0;
      end else if (run) begin
        cnt <= cnt + 7'd1;
        if (cnt == 7'(NB - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      neg <= sum[63];
      num <= {(sum[63] ? (64'd0 - sum) : sum), 16'd0};
      rem <= 49'd0;
      div <= weight;
    end else if (run) begin
      num <= {num[NB-2:0], ge};
      rem <= ge ? (rem_sh - {1'b0, div}) : rem_sh;
    end
  end

  always_comb begin
    if (neg) quot = (num[NB-1:63] != '0) ? gbwa_pkg::S64_MIN : (64'd0 - num[63:0]);
    else     quot = (num[NB-1:63] != '0) ? gbwa_pkg::S64_MAX : num[63:0];
  end
endmodule

// ----- rtl/gbwa_back.sv -----
// back end: key search, read-modify-write of the group tables and readout
module gbwa_back #(
  parameter int MAX_GROUPS = gbwa_pkg::GBWA_MAX_GROUPS,
  parameter int VARS       = gbwa_pkg::GBWA_VARS,
  parameter int KEY_BITS   = gbwa_pkg::GBWA_KEY_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              mean_mode,
  input  gbwa_pkg::qhead_t  head,
  output logic              pop,
  output logic              res_valid,
  output gbwa_pkg::result_t res
);
  localparam int GW  = $clog2(MAX_GROUPS);
  localparam int GCW = $clog2(MAX_GROUPS + 1);
  localparam int CW  = (GCW > 9) ? GCW : 9;

  gbwa_pkg::bstate_t state, state_next;
  logic [GCW-1:0] used, used_next;
  gbwa_pkg::item_t cur, cur_next;
  logic [GW-1:0]  g, g_next;
  logic           created, created_next;
  logic [GCW-1:0] scan, scan_next;
  logic           cmp_vld, cmp_vld_next;
  logic [GW-1:0]  cmp_idx, cmp_idx_next;
  logic [1:0]     var_i, var_i_next;
  logic [63:0]    prod, prod_next;
  gbwa_pkg::result_t res_next;

  logic [KEY_BITS-1:0] key_mem [MAX_GROUPS];
  logic [47:0]         w_mem   [MAX_GROUPS];
  logic [63:0]         s_mem   [MAX_GROUPS*4];
  logic [KEY_BITS-1:0] key_rd;
  logic [47:0]         w_rd;
  logic [63:0]         s_rd;
  logic [GW-1:0]       k_addr;
  logic                k_we, w_we, s_we;
  logic [47:0]         w_wd;
  logic [63:0]         s_wd;

  logic        div_go, div_done;
  logic [63:0] div_q;
  logic        set_res;
  logic [63:0] set_val;
  logic        adv;
  logic [31:0] val_sel;
  logic signed [64:0] pw;
  logic [48:0] wsum;
  logic [47:0] w_old;
  logic [63:0] s_old, s_new;

  gbwa_div u_div (
    .clk(clk), .rst(rst), .go(div_go), .sum(s_rd), .weight(w_rd),
    .done(div_done), .quot(div_q)
  );

  // table memories, registered reads
  // a new key is written during search, where scan has reached used
  assign k_addr = (state == gbwa_pkg::B_SRCH) ? scan[GW-1:0] : g;
  always_ff @(posedge clk) begin
    if (k_we) key_mem[k_addr] <= cur.group_key[KEY_BITS-1:0];
    key_rd <= key_mem[k_addr];
  end
  always_ff @(posedge clk) begin
    if (w_we) w_mem[g] <= w_wd;
    w_rd <= w_mem[g];
  end
  always_ff @(posedge clk) begin
    if (s_we) s_mem[{g, var_i}] <= s_wd;
    s_rd <= s_mem[{g, var_i}];
  end

  always_comb begin
    unique case (var_i)
      2'd0: val_sel = cur.value_0;
      2'd1: val_sel = cur.value_1;
      2'd2: val_sel = cur.value_2;
      2'd3: val_sel = cur.value_3;
    endcase
  end

  assign pw    = $signed({1'b0, cur.obs_weight}) * $signed(val_sel);
  assign w_old = created ? 48'd0 : w_rd;
  assign wsum  = {1'b0, w_old} + 49'(cur.obs_weight);
  assign s_old = created ? 64'd0 : s_rd;
  assign s_new = gbwa_pkg::sat_add(s_old, prod);
  assign w_wd  = wsum[48] ? gbwa_pkg::W48_MAX : wsum[47:0];
  assign s_wd  = s_new;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gbwa_pkg::B_IDLE;
      used  <= '0;
    end else begin
      state <= state_next;
      used  <= used_next;
    end
  end

  always_ff @(posedge clk) begin
    cur     <= cur_next;
    g       <= g_next;
    created <= created_next;
    scan    <= scan_next;
    cmp_vld <= cmp_vld_next;
    cmp_idx <= cmp_idx_next;
    var_i   <= var_i_next;
    prod    <= prod_next;
    res     <= res_next;
  end

  always_comb begin
    state_next   = state;
    used_next    = used;
    cur_next     = cur;
    g_next       = g;
    created_next = created;
    scan_next    = scan;
    cmp_vld_next = 1'b0;
    cmp_idx_next = cmp_idx;
    var_i_next   = var_i;
    prod_next    = prod;
    res_next     = res;
    pop          = 1'b0;
    k_we         = 1'b0;
    w_we         = 1'b0;
    s_we         = 1'b0;
    div_go       = 1'b0;
    set_res      = 1'b0;
    set_val      = 64'd0;
    adv          = 1'b0;
    res_valid    = 1'b0;

    unique case (state)
      gbwa_pkg::B_IDLE: begin
        if (head.valid) begin
          pop          = 1'b1;
          cur_next     = head.item;
          res_next     = '0;
          created_next = 1'b0;
          var_i_next   = 2'd0;
          scan_next    = '0;
          if (head.item.action == gbwa_pkg::ACT_ACCUM) begin
            state_next = gbwa_pkg::B_SRCH;
          end else begin
            res_next.group_index = head.item.read_index;
            g_next = GW'(head.item.read_index);
            if (CW'(head.item.read_index) >= CW'(used)) begin
              res_next.error_flag = 1'b1;
              state_next = gbwa_pkg::B_DONE;
            end else begin
              state_next = gbwa_pkg::B_WRD;
            end
          end
        end
      end
      gbwa_pkg::B_SRCH: begin
        // one key read issued per cycle, compared the cycle after
        if (cmp_vld && key_rd == cur.group_key[KEY_BITS-1:0]) begin
          g_next     = cmp_idx;
          state_next = gbwa_pkg::B_WRD;
        end else if (scan < used) begin
          cmp_vld_next = 1'b1;
          cmp_idx_next = scan[GW-1:0];
          scan_next    = scan + 1'b1;
        end else if (!cmp_vld) begin
          if (used >= GCW'(MAX_GROUPS)) begin
            res_next.error_flag = 1'b1;
            res_next.out_key    = cur.group_key;
            state_next = gbwa_pkg::B_DONE;
          end else begin
            g_next       = used[GW-1:0];
            created_next = 1'b1;
            used_next    = used + 1'b1;
            k_we         = 1'b1;
            state_next   = gbwa_pkg::B_WRD;
          end
        end
      end
      gbwa_pkg::B_WRD: begin
        state_next = gbwa_pkg::B_WUPD;
      end
      gbwa_pkg::B_WUPD: begin
        res_next.group_index = 8'(g);
        res_next.created     = created;
        res_next.out_key     = 64'(key_rd);
        if (cur.action == gbwa_pkg::ACT_ACCUM) begin
          w_we = 1'b1;
          res_next.total_weight = w_wd;
          state_next = gbwa_pkg::B_SRD;
        end else if (mean_mode && w_rd == 48'd0) begin
          res_next.error_flag = 1'b1;
          state_next = gbwa_pkg::B_DONE;
        end else begin
          res_next.total_weight = w_rd;
          state_next = gbwa_pkg::B_SRD;
        end
      end
      gbwa_pkg::B_SRD: begin
        prod_next  = pw[63:0];
        state_next = gbwa_pkg::B_SUPD;
      end
      gbwa_pkg::B_SUPD: begin
        if (cur.action == gbwa_pkg::ACT_ACCUM) begin
          s_we    = 1'b1;
          set_res = 1'b1;
          set_val = s_new;
          adv     = 1'b1;
        end else if (mean_mode) begin
          div_go     = 1'b1;
          state_next = gbwa_pkg::B_DIV;
        end else begin
          set_res = 1'b1;
          set_val = s_rd;
          adv     = 1'b1;
        end
      end
      gbwa_pkg::B_DIV: begin
        if (div_done) begin
          set_res = 1'b1;
          set_val = div_q;
          adv     = 1'b1;
        end
      end
      gbwa_pkg::B_DONE: begin
        res_valid  = 1'b1;
        state_next = gbwa_pkg::B_IDLE;
      end
      default: state_next = gbwa_pkg::B_IDLE;
    endcase

    if (set_res) begin
      unique case (var_i)
        2'd0: res_next.result_0 = set_val;
        2'd1: res_next.result_1 = set_val;
        2'd2: res_next.result_2 = set_val;
        2'd3: res_next.result_3 = set_val;
      endcase
    end
    if (adv) begin
      if (var_i == 2'(VARS - 1)) begin
        state_next = gbwa_pkg::B_DONE;
      end else begin
        var_i_next = var_i + 2'd1;
        state_next = gbwa_pkg::B_SRD;
      end
    end
    if (state_next == gbwa_pkg::B_DONE && state != gbwa_pkg::B_DONE)
      res_next.group_count = 9'(used_next);
  end
endmodule

// ----- rtl/group_by_weighted_aggregator.sv -----
// top level of the group-by weighted aggregation table
// a command is taken when start is high and busy is low; a two-entry queue
// holds commands while the back end works, so busy rises only when it is full.
// an accumulate searches the stored keys one per cycle, the single key memory
// read port setting that pace. a mean readout adds a bit-serial divide per
// variable. each result beat shows on res for exactly one cycle with
// res_valid high; the receiver cannot stall it. the tables need no clearing
// pass: only groups below the stored count are ever read. mean_mode is
// written through the cfg channel, which is always ready; the user must
// write it only while idle, which the block itself does not enforce.
module group_by_weighted_aggregator #(
  parameter int MAX_GROUPS = gbwa_pkg::GBWA_MAX_GROUPS,
  parameter int VARS       = gbwa_pkg::GBWA_VARS,
  parameter int KEY_BITS   = gbwa_pkg::GBWA_KEY_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  gbwa_pkg::item_t   item,
  output logic              res_valid,
  output gbwa_pkg::result_t res,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_data
);
  gbwa_pkg::qhead_t head;
  logic             pop;
  logic             mean_mode;

  // config register, one bit
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      mean_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      mean_mode <= cfg_data;
    end
  end

  // intake and queue
  gbwa_front #(.KEY_BITS(KEY_BITS)) u_front (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .head(head), .pop(pop)
  );

  // search, update and readout engine
  gbwa_back #(.MAX_GROUPS(MAX_GROUPS), .VARS(VARS), .KEY_BITS(KEY_BITS)) u_back (
    .clk(clk), .rst(rst), .mean_mode(mean_mode), .head(head), .pop(pop),
    .res_valid(res_valid), .res(res)
  );
endmodule

// ----- rtl/gbwa_checker.sv -----
// port-level checks for the aggregator, bound to the top level
module gbwa_checker (
  input logic              clk,
  input logic              rst,
  input logic              res_valid,
  input gbwa_pkg::result_t res
);
  a_strobe_single: assert property (@(posedge clk) disable iff (rst)
    res_valid |=> !res_valid) else $error("result strobe held two cycles");
  a_quiet_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !res_valid) else $error("result right after reset");
  a_created_ok: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.created |-> !res.error_flag && res.group_count != 9'd0)
    else $error("created group flagged or count empty");
  a_error_no_weight: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.error_flag |-> res.total_weight == 48'd0)
    else $error("error beat carries weight");
endmodule

bind group_by_weighted_aggregator gbwa_checker u_gbwa_checker (
  .clk(clk), .rst(rst), .res_valid(res_valid), .res(res)
);

// ----- tb/group_by_weighted_aggregator_tb.sv -----
// self-checking testbench for the group-by weighted aggregation table
module group_by_weighted_aggregator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NGROUPS = gbwa_pkg::GBWA_MAX_GROUPS;
  localparam longint CYCLE_LIMIT = 64'd3_000_000;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  logic    busy;
  gbwa_pkg::item_t   item = '0;
  logic    res_valid;
  gbwa_pkg::result_t res;
  logic    cfg_valid = 1'b0;
  logic    cfg_ready;
  logic    cfg_data = 1'b0;

  always #5 clk = ~clk;

  group_by_weighted_aggregator u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .res_valid(res_valid), .res(res),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // shadow copy of the table state
  int unsigned  shadow_used;
  logic [63:0]  shadow_keys [NGROUPS];
  logic [47:0]  shadow_wts  [NGROUPS];
  logic [63:0]  shadow_sums [NGROUPS][4];
  logic         shadow_mean;

  gbwa_pkg::result_t pending_results [$];
  int      mismatches = 0;
  int      checked = 0;
  longint  cycles = 0;
  int      send_idle_pct = 0;
  int      items_sent = 0;
  bit      fail_seen = 0;

  // weight times signed value, exact Q32.32
  function automatic logic [63:0] weighted_value(logic [31:0] w, logic [31:0] v);
    logic [63:0] mag;
    logic [63:0] p;
    mag = v[31] ? {32'd0, (~v + 32'd1)} : {32'd0, v};
    p = {32'd0, w} * mag;
    return v[31] ? (~p + 64'd1) : p;
  endfunction

  function automatic logic [63:0] add_clamped(logic [63:0] a, logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63])
      return a[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    return s;
  endfunction

  // (sum << 16) / w, toward zero, clamped to 64 bits
  function automatic logic [63:0] mean_of(logic [63:0] sum, logic [47:0] w);
    logic [63:0]  mag;
    logic [127:0] q;
    mag = sum[63] ? (~sum + 64'd1) : sum;
    q = {48'd0, mag, 16'd0} / {80'd0, w};
    if (sum[63])
      return (q >= 128'h8000_0000_0000_0000) ? 64'h8000_0000_0000_0000
                                             : (~q[63:0] + 64'd1);
    return (q > 128'h7FFF_FFFF_FFFF_FFFF) ? 64'h7FFF_FFFF_FFFF_FFFF : q[63:0];
  endfunction

  // predicts one beat and updates the shadow table
  function automatic gbwa_pkg::result_t aggregate_predict(gbwa_pkg::item_t it);
    gbwa_pkg::result_t r;
    int g;
    logic [48:0] nw;
    logic [63:0] rs [4];
    r = '0;
    if (it.action == gbwa_pkg::ACT_ACCUM) begin
      g = -1;
      for (int k = 0; k < shadow_used; k++)
        if (g < 0 && shadow_keys[k] == it.group_key) g = k;
      if (g < 0) begin
        if (shadow_used >= NGROUPS) begin
          r.error_flag = 1'b1;
          r.out_key = it.group_key;
          r.group_count = shadow_used[8:0];
          return r;
        end
        g = shadow_used;
        shadow_used++;
        shadow_keys[g] = it.group_key;
        shadow_wts[g] = '0;
        for (int i = 0; i < 4; i++) shadow_sums[g][i] = '0;
        r.created = 1'b1;
      end
      nw = {1'b0, shadow_wts[g]} + {17'd0, it.obs_weight};
      shadow_wts[g] = nw[48] ? gbwa_pkg::W48_MAX : nw[47:0];
      shadow_sums[g][0] = add_clamped(shadow_sums[g][0],
                                      weighted_value(it.obs_weight, it.value_0));
      shadow_sums[g][1] = add_clamped(shadow_sums[g][1],
                                      weighted_value(it.obs_weight, it.value_1));
      shadow_sums[g][2] = add_clamped(shadow_sums[g][2],
                                      weighted_value(it.obs_weight, it.value_2));
      shadow_sums[g][3] = add_clamped(shadow_sums[g][3],
                                      weighted_value(it.obs_weight, it.value_3));
      r.group_index = g[7:0];
      r.out_key = shadow_keys[g];
      r.total_weight = shadow_wts[g];
      r.result_0 = shadow_sums[g][0];
      r.result_1 = shadow_sums[g][1];
      r.result_2 = shadow_sums[g][2];
      r.result_3 = shadow_sums[g][3];
    end else begin
      g = it.read_index;
      r.group_index = it.read_index;
      if (g >= shadow_used) begin
        r.error_flag = 1'b1;
      end else if (shadow_mean && shadow_wts[g] == '0) begin
        r.error_flag = 1'b1;
        r.out_key = shadow_keys[g];
      end else begin
        r.out_key = shadow_keys[g];
        r.total_weight = shadow_wts[g];
        for (int i = 0; i < 4; i++)
          rs[i] = shadow_mean ? mean_of(shadow_sums[g][i], shadow_wts[g])
                              : shadow_sums[g][i];
        r.result_0 = rs[0];
        r.result_1 = rs[1];
        r.result_2 = rs[2];
        r.result_3 = rs[3];
      end
    end
    r.group_count = shadow_used[8:0];
    return r;
  endfunction

  // result checker: every strobed beat against the oldest prediction
  always @(posedge clk) begin
    gbwa_pkg::result_t exp_r;
    cycles <= cycles + 1;
    if (!rst && res_valid) begin
      if (pending_results.size() == 0) begin
        fail_seen = 1;
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: %p", res);
      end else begin
        exp_r = pending_results.pop_front();
        checked++;
        if (res !== exp_r) begin
          fail_seen = 1;
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch\n  expected %p\n  actual   %p", exp_r, res);
        end
      end
    end
  end

  // watchdog on the whole run
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("group_by_weighted_aggregator_tb failed");
      $finish;
    end
  end

  // one command beat, with random idle cycles ahead of it
  // start stays high after the beat; an idle cycle or drain drops it
  task automatic send_item(gbwa_pkg::item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    item <= it;
    pending_results.push_back(aggregate_predict(it));
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // mean_mode written only with the table idle
  task automatic write_mode(logic m);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    shadow_mean = m;
  endtask

  function automatic gbwa_pkg::item_t accum(logic [63:0] k, logic [31:0] w,
                                            logic [31:0] a, logic [31:0] b,
                                            logic [31:0] c, logic [31:0] d);
    gbwa_pkg::item_t it;
    it = '0;
    it.action = gbwa_pkg::ACT_ACCUM;
    it.group_key = k;
    it.obs_weight = w;
    it.value_0 = a;
    it.value_1 = b;
    it.value_2 = c;
    it.value_3 = d;
    it.read_index = 8'($urandom);
    return it;
  endfunction

  function automatic gbwa_pkg::item_t readout(logic [7:0] idx);
    gbwa_pkg::item_t it;
    it = '0;
    it.action = gbwa_pkg::ACT_READ;
    it.read_index = idx;
    it.group_key = {$urandom, $urandom};
    it.obs_weight = $urandom;
    return it;
  endfunction

  function automatic logic [31:0] rand_value();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(131072) - 65536;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_weight();
    case ($urandom_range(5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h0001_0000;
      default: return $urandom;
    endcase
  endfunction

  // extremes, saturation, zero weight, bad index, in both modes
  task automatic test_directed();
    send_item(readout(8'd0));
    send_item(accum(64'd0, 32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000, 0, 1));
    send_item(accum(64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                    32'h8000_0000, 32'hFFFF_FFFF, 32'h0));
    repeat (5)
      send_item(accum(64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                      32'h8000_0000, 32'h1, 32'h8000_0000));
    send_item(accum(64'hA5A5_5A5A_0F0F_F0F0, 32'd0, 32'h1234_5678, 0, 0, 0));
    send_item(readout(8'd1));
    send_item(readout(8'd2));
    send_item(readout(8'd255));
    send_item(readout(8'd3));
    write_mode(1'b1);
    send_item(readout(8'd0));
    send_item(readout(8'd1));
    send_item(readout(8'd2));
    send_item(readout(8'd200));
    write_mode(1'b0);
  endtask

  // random mix, keys drawn mostly from a small pool so groups get hits
  task automatic test_random(int n, int idle_pct);
    logic [63:0] k;
    send_idle_pct = idle_pct;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0) begin
        send_item(readout(8'($urandom_range(3) == 0 ? $urandom
                                                    : $urandom_range(shadow_used + 1))));
      end else begin
        k = ($urandom_range(2) == 0) ? {$urandom, $urandom}
                                     : 64'(32'h100 + $urandom_range(15));
        send_item(accum(k, rand_weight(), rand_value(), rand_value(),
                        rand_value(), rand_value()));
      end
    end
  endtask

  // fill to 256 groups, then overflow, then read the last entry and the first
  task automatic test_table_full();
    send_idle_pct = 0;
    while (shadow_used < NGROUPS)
      send_item(accum({32'hF000_0000, 32'(shadow_used)}, $urandom, $urandom,
                      $urandom, $urandom, $urandom));
    send_item(accum(64'hDEAD_0000_0000_0001, 32'h1_0000, 1, 2, 3, 4));
    send_item(accum({32'hF000_0000, 32'd255}, 32'h1_0000, 1, 2, 3, 4));
    send_item(readout(8'd255));
    write_mode(1'b1);
    send_item(readout(8'd255));
    send_item(readout(8'd0));
    send_item(accum(64'hDEAD_0000_0000_0002, 32'd5, 0, 0, 0, 0));
  endtask

  initial begin
    shadow_used = 0;
    shadow_mean = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(200, 25);
    write_mode(1'b1);
    test_random(150, 66);
    write_mode(1'b0);
    test_random(100, 0);
    test_table_full();
    test_random(50, 0);
    write_mode(1'b0);
    test_random(30, 25);
    drain();
    $display("covered %0d items, %0d results checked, both modes, full table",
             items_sent, checked);
    if (!fail_seen && mismatches == 0) begin
      $display("group_by_weighted_aggregator_tb passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("group_by_weighted_aggregator_tb failed");
    end
    $finish;
  end

endmodule
